/* design/csvtok_pkg.sv */
// Package for the CSV field tokenizer: token codes, byte constants, token types
// and the per-byte tokenizing function. No dependencies.
`default_nettype none

package csvtok_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned KindW    = 2;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  // token codes
  localparam logic [KindW-1:0] TOK_CONTENT = 2'd0;
  localparam logic [KindW-1:0] TOK_FIELD   = 2'd1;
  localparam logic [KindW-1:0] TOK_RECORD  = 2'd2;

  // input item kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // register indexes
  localparam logic REG_SEPARATOR = 1'b0;
  localparam logic REG_QUOTE     = 1'b1;

  localparam logic [ByteW-1:0] CR_BYTE       = 8'h0D;
  localparam logic [ByteW-1:0] LF_BYTE       = 8'h0A;
  localparam logic [ByteW-1:0] SEP_RESET     = 8'd44;
  localparam logic [ByteW-1:0] QUOTE_RESET   = 8'd34;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] data;
  } tok_t;

  // up to two tokens from one input item, in order
  typedef struct packed {
    logic [1:0] cnt;
    tok_t       tok0;
    tok_t       tok1;
  } tok_pair_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] data;
    logic             last;
  } q_entry_t;

  typedef struct packed {
    logic iq;
    logic qp;
    logic emit;
    tok_t tok;
  } take_t;

  // process one byte against the quote state
  function automatic take_t take_byte(input logic iq, input logic qp,
                                      input logic [ByteW-1:0] c,
                                      input logic [ByteW-1:0] sep,
                                      input logic [ByteW-1:0] quo);
    take_t r;
    logic  iq_w;
    r.iq       = iq;
    r.qp       = 1'b0;
    r.emit     = 1'b0;
    r.tok.kind = TOK_CONTENT;
    r.tok.data = c;
    iq_w       = iq & ~qp;
    if (qp && (c == quo)) begin
      // doubled quote gives a literal
      r.emit = 1'b1;
    end else begin
      r.iq = iq_w;
      if (iq_w) begin
        if (c == quo) begin
          r.qp = 1'b1;
        end else begin
          r.emit = 1'b1;
        end
      end else if (c == quo) begin
        r.iq = 1'b1;
      end else if (c == sep) begin
        r.emit     = 1'b1;
        r.tok.kind = TOK_FIELD;
        r.tok.data = '0;
      end else begin
        r.emit = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/csvtok_core.sv */
// Tokenizer core: configuration registers, quote/line state and the single-pass
// step that turns one input item into up to two tokens. Uses csvtok_pkg.
`default_nettype none

module csvtok_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_index_i,
  input  wire logic [csvtok_pkg::ByteW-1:0]  cfg_data_i,
  input  wire logic                          fire_i,
  input  wire logic                          kind_i,
  input  wire logic [csvtok_pkg::ByteW-1:0]  data_byte_i,
  output csvtok_pkg::tok_pair_t              pair_o
);

  logic [csvtok_pkg::ByteW-1:0] sep_q, quo_q;
  logic iq_q, iq_d, qp_q, qp_d, rp_q, rp_d, lne_q, lne_d;

  csvtok_pkg::take_t t_cr, t_c;
  logic iq_1, qp_1;
  logic e0, e1;
  csvtok_pkg::tok_t tk0, tk1;
  logic line_end;

  // hold configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q <= csvtok_pkg::SEP_RESET;
      quo_q <= csvtok_pkg::QUOTE_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == csvtok_pkg::REG_SEPARATOR) begin
        sep_q <= cfg_data_i;
      end else begin
        quo_q <= cfg_data_i;
      end
    end
  end

  // step: released carriage return first, then the new byte
  always_comb begin
    line_end = (kind_i == csvtok_pkg::KIND_END) || (data_byte_i == csvtok_pkg::LF_BYTE);
    t_cr = csvtok_pkg::take_byte(iq_q, qp_q, csvtok_pkg::CR_BYTE, sep_q, quo_q);
    iq_1 = rp_q ? t_cr.iq : iq_q;
    qp_1 = rp_q ? t_cr.qp : qp_q;
    t_c  = csvtok_pkg::take_byte(iq_1, qp_1, data_byte_i, sep_q, quo_q);

    iq_d  = iq_q;
    qp_d  = qp_q;
    rp_d  = rp_q;
    lne_d = lne_q;
    e0    = 1'b0;
    e1    = 1'b0;
    tk0   = t_cr.tok;
    tk1   = t_c.tok;
    if (line_end) begin
      // end the line, drop any held carriage return
      iq_d     = 1'b0;
      qp_d     = 1'b0;
      rp_d     = 1'b0;
      lne_d    = 1'b0;
      e0       = lne_q;
      tk0.kind = csvtok_pkg::TOK_RECORD;
      tk0.data = '0;
    end else if (data_byte_i == csvtok_pkg::CR_BYTE) begin
      iq_d  = iq_1;
      qp_d  = qp_1;
      rp_d  = 1'b1;
      lne_d = lne_q | rp_q;
      e0    = rp_q & t_cr.emit;
    end else begin
      iq_d  = t_c.iq;
      qp_d  = t_c.qp;
      rp_d  = 1'b0;
      lne_d = 1'b1;
      e0    = rp_q & t_cr.emit;
      e1    = t_c.emit;
    end

    // pack emitted tokens into the front slots
    pair_o.cnt  = {1'b0, e0} + {1'b0, e1};
    pair_o.tok0 = e0 ? tk0 : tk1;
    pair_o.tok1 = tk1;
  end

  // advance state on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iq_q  <= 1'b0;
      qp_q  <= 1'b0;
      rp_q  <= 1'b0;
      lne_q <= 1'b0;
    end else if (fire_i) begin
      iq_q  <= iq_d;
      qp_q  <= qp_d;
      rp_q  <= rp_d;
      lne_q <= lne_d;
    end
  end

  // a pending quote only exists inside quotes
  assert property (@(posedge clk_i) disable iff (!rst_ni) qp_q |-> iq_q)
    else $error("quote pending outside quotes");
  // end of input leaves clean line state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && kind_i == csvtok_pkg::KIND_END) |=> (!iq_q && !qp_q && !rp_q && !lne_q))
    else $error("line state not cleared at end of input");

endmodule

`default_nettype wire

/* design/csvtok_outq.sv */
// Result queue: takes up to two tokens per input transfer, hands out one per
// output transfer and marks the last token of each item. Uses csvtok_pkg.
`default_nettype none

module csvtok_outq (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              push_i,
  input  wire csvtok_pkg::tok_pair_t             pair_i,
  output logic                                   room_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [csvtok_pkg::KindW-1:0]           token_kind_o,
  output logic [csvtok_pkg::ByteW-1:0]           content_byte_o,
  output logic                                   last_of_run_o
);

  csvtok_pkg::q_entry_t mem_q [csvtok_pkg::QDepth];
  logic [csvtok_pkg::QPtrW-1:0] wr_q, rd_q, wr_p1;
  logic [csvtok_pkg::QCntW-1:0] cnt_q, cnt_d;
  logic [1:0] push_n;
  logic       pop;

  assign push_n      = push_i ? pair_i.cnt : 2'd0;
  assign pop         = out_valid_o && out_ready_i;
  assign room_o      = cnt_q <= csvtok_pkg::QCntW'(csvtok_pkg::QDepth - 2);
  assign out_valid_o = cnt_q != '0;
  assign wr_p1       = wr_q + 1'b1;
  assign cnt_d       = cnt_q + csvtok_pkg::QCntW'(push_n) - csvtok_pkg::QCntW'(pop);

  assign token_kind_o   = mem_q[rd_q].kind;
  assign content_byte_o = mem_q[rd_q].data;
  assign last_of_run_o  = mem_q[rd_q].last;

  // write emitted tokens
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      mem_q[wr_q] <= '{kind: pair_i.tok0.kind, data: pair_i.tok0.data,
                       last: (pair_i.cnt == 2'd1)};
    end
    if (push_n == 2'd2) begin
      mem_q[wr_p1] <= '{kind: pair_i.tok1.kind, data: pair_i.tok1.data, last: 1'b1};
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + csvtok_pkg::QPtrW'(push_n);
      rd_q  <= rd_q + csvtok_pkg::QPtrW'(pop);
      cnt_q <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= csvtok_pkg::QCntW'(csvtok_pkg::QDepth))
    else $error("result queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (pair_i.cnt != 2'd3))
    else $error("more than two tokens from one item");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && cnt_q == 3'd1 && push_n == 2'd0) |=> !out_valid_o)
    else $error("queue not empty after draining last token");

endmodule

`default_nettype wire

/* design/csv_field_tokenizer_unit.sv */
// Top level of the CSV field tokenizer: tokenizer core plus result queue.
// Depends on csvtok_pkg, csvtok_core and csvtok_outq.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_ready_o    kind_i, data_byte_i
//   out      output     out_valid_o / out_ready_i  token_kind_o, content_byte_o, last_of_run_o
//   cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One input item per cycle while the result queue has room; each item yields zero,
// one or two tokens, and the output drains one token per cycle while out_ready_i is high.
// Input is taken while the four-entry result queue has room for two tokens.
// Tokens are written into the queue at their input transfer and leave it in order.
// Reset clears quote and line state, empties the queue and restores the
// separator (44) and quote (34) registers. cfg_ready_o is always high.
`default_nettype none

module csv_field_tokenizer_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic                          cfg_index_i,
  input  wire logic [csvtok_pkg::ByteW-1:0]  cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          kind_i,
  input  wire logic [csvtok_pkg::ByteW-1:0]  data_byte_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [csvtok_pkg::KindW-1:0]       token_kind_o,
  output logic [csvtok_pkg::ByteW-1:0]       content_byte_o,
  output logic                               last_of_run_o
);

  logic                  fire;
  csvtok_pkg::tok_pair_t pair;

  assign cfg_ready_o = 1'b1;
  assign fire        = in_valid_i && in_ready_o;

  csvtok_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fire_i      (fire),
    .kind_i      (kind_i),
    .data_byte_i (data_byte_i),
    .pair_o      (pair)
  );

  csvtok_outq u_outq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (fire),
    .pair_i         (pair),
    .room_o         (in_ready_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .token_kind_o   (token_kind_o),
    .content_byte_o (content_byte_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

`default_nettype wire
